>>> hw/rtl/bpc_pkg.sv
// Shared types, constants and helpers for the button press classifier.
`timescale 1ns / 1ps
package bpc_pkg;

  localparam int unsigned OUT_BUTTONS = 4;
  localparam int unsigned KNOB_COUNT  = 4;
  localparam int unsigned MASK_W      = 4;
  localparam int unsigned STAMP_W     = 32;
  localparam int unsigned THRESH_W    = 16;
  localparam int unsigned RAW_W       = 10;
  localparam int unsigned SCALED_W    = 16;
  localparam int unsigned CFG_INDEX_W = 2;

  localparam logic [RAW_W:0] KNOB_DIVISOR = 11'd1023;

  localparam logic [THRESH_W-1:0] LONG_RESET = 16'd500;
  localparam logic [THRESH_W-1:0] HOLD_RESET = 16'd1000;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_LONG_PRESS = 2'd0,
    REG_HOLD_PRESS = 2'd1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    CLASS_NONE  = 2'd0,
    CLASS_SHORT = 2'd1,
    CLASS_LONG  = 2'd2,
    CLASS_HOLD  = 2'd3
  } press_class_e;

  // Per-lane strobes for one accepted beat.
  typedef struct packed {
    logic accept;
    logic rise;
    logic fall;
  } lane_ctrl_t;

  // floor(raw * 65535 / 1023) = 64 * raw + floor(63 * raw / 1023).
  // The small quotient uses x = 1024 * q0 + lo = 1023 * q0 + (q0 + lo),
  // and q0 + lo stays below twice the divisor, so one correction suffices.
  function automatic logic [SCALED_W-1:0] knob_scale(input logic [RAW_W-1:0] raw);
    logic [15:0]    x;
    logic [5:0]     q0;
    logic [RAW_W:0] rem;
    logic [5:0]     q;
    x   = ({6'd0, raw} << 6) - {6'd0, raw};
    q0  = x[15:10];
    rem = {1'b0, x[9:0]} + {5'd0, q0};
    if (rem >= KNOB_DIVISOR) begin
      q = q0 + 6'd1;
    end else begin
      q = q0;
    end
    return {raw, 6'd0} + {10'd0, q};
  endfunction

endpackage

>>> hw/rtl/bpc_button_lane.sv
// One button lane: edge stamps, pair tracking and press classification.
`timescale 1ns / 1ps
module bpc_button_lane (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  bpc_pkg::lane_ctrl_t                 ctrl_i,
  input  logic [bpc_pkg::STAMP_W-1:0]         now_ms_i,
  input  logic [bpc_pkg::THRESH_W-1:0]        long_press_ms_i,
  input  logic [bpc_pkg::THRESH_W-1:0]        hold_press_ms_i,
  output bpc_pkg::press_class_e               press_class_o
);

  logic [bpc_pkg::STAMP_W-1:0] press_stamp_q, press_stamp_d;
  logic [bpc_pkg::STAMP_W-1:0] release_stamp_q, release_stamp_d;
  logic                        press_valid_q, release_valid_q;
  logic                        press_valid_d, release_valid_d;
  bpc_pkg::press_class_e       last_class_q, class_d;
  logic [bpc_pkg::STAMP_W-1:0] duration, held;

  always_comb begin
    press_stamp_d   = ctrl_i.rise ? now_ms_i : press_stamp_q;
    release_stamp_d = ctrl_i.fall ? now_ms_i : release_stamp_q;
    press_valid_d   = press_valid_q | ctrl_i.rise;
    release_valid_d = release_valid_q | ctrl_i.fall;
    duration        = release_stamp_d - press_stamp_d;
    held            = now_ms_i - press_stamp_d;
    class_d         = bpc_pkg::CLASS_NONE;
    if (press_valid_d && release_valid_d) begin
      // a pair closes: report unless the press was already reported as hold
      if (last_class_q == bpc_pkg::CLASS_HOLD) begin
        class_d = bpc_pkg::CLASS_NONE;
      end else if (duration < {16'd0, long_press_ms_i}) begin
        class_d = bpc_pkg::CLASS_SHORT;
      end else begin
        class_d = bpc_pkg::CLASS_LONG;
      end
      press_valid_d   = 1'b0;
      release_valid_d = 1'b0;
    end else if (press_valid_d && (held > {16'd0, hold_press_ms_i})) begin
      class_d = bpc_pkg::CLASS_HOLD;
    end
  end

  assign press_class_o = class_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      press_valid_q   <= 1'b0;
      release_valid_q <= 1'b0;
      last_class_q    <= bpc_pkg::CLASS_NONE;
    end else if (ctrl_i.accept) begin
      press_valid_q   <= press_valid_d;
      release_valid_q <= release_valid_d;
      last_class_q    <= class_d;
    end
  end

  // stamps are read only while their valid flag is set
  always_ff @(posedge clk_i) begin
    if (ctrl_i.accept) begin
      press_stamp_q   <= press_stamp_d;
      release_stamp_q <= release_stamp_d;
    end
  end

endmodule

>>> hw/rtl/button_press_classifier.sv
// Button press classifier top level: button lanes, knob scaling, output register.
// Each accepted input beat gives its result beat on the outputs the next cycle.
// Throughput: one beat per cycle unless a result stalls; each button has its own
// lane, all in one stage. The output register refills in the cycle it drains; a
// stalled result holds the input off while it waits.
// Reset (async, active low) clears lane flags, last classes and the output valid;
// thresholds return to 500 ms (long) and 1000 ms (hold).
`timescale 1ns / 1ps
module button_press_classifier #(
  parameter int unsigned BUTTON_COUNT = 4
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration write channel
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [bpc_pkg::CFG_INDEX_W-1:0]   cfg_index_i,
  input  logic [bpc_pkg::THRESH_W-1:0]      cfg_data_i,
  // input beat
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [bpc_pkg::MASK_W-1:0]        rising_mask_i,
  input  logic [bpc_pkg::MASK_W-1:0]        falling_mask_i,
  input  logic [bpc_pkg::STAMP_W-1:0]       now_ms_i,
  input  logic [bpc_pkg::RAW_W-1:0]         knob_raw_0_i,
  input  logic [bpc_pkg::RAW_W-1:0]         knob_raw_1_i,
  input  logic [bpc_pkg::RAW_W-1:0]         knob_raw_2_i,
  input  logic [bpc_pkg::RAW_W-1:0]         knob_raw_3_i,
  // result beat
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [1:0]                        press_class_0_o,
  output logic [1:0]                        press_class_1_o,
  output logic [1:0]                        press_class_2_o,
  output logic [1:0]                        press_class_3_o,
  output logic [bpc_pkg::SCALED_W-1:0]      knob_scaled_0_o,
  output logic [bpc_pkg::SCALED_W-1:0]      knob_scaled_1_o,
  output logic [bpc_pkg::SCALED_W-1:0]      knob_scaled_2_o,
  output logic [bpc_pkg::SCALED_W-1:0]      knob_scaled_3_o
);

  // Buttons past the mask width never see an edge and never reach a port,
  // so only the first four get a lane.
  localparam int unsigned LANES =
    (BUTTON_COUNT < bpc_pkg::OUT_BUTTONS) ? BUTTON_COUNT : bpc_pkg::OUT_BUTTONS;

  logic [bpc_pkg::THRESH_W-1:0] long_press_q, hold_press_q;
  logic                         accept;
  logic                         out_valid_q;

  bpc_pkg::press_class_e        lane_class [bpc_pkg::OUT_BUTTONS];
  bpc_pkg::press_class_e        class_q    [bpc_pkg::OUT_BUTTONS];
  logic [bpc_pkg::RAW_W-1:0]    knob_raw   [bpc_pkg::KNOB_COUNT];
  logic [bpc_pkg::SCALED_W-1:0] knob_q     [bpc_pkg::KNOB_COUNT];

  // ---------------------------------------------------------------------------
  // Configuration: always ready, unknown indexes drop silently.
  // ---------------------------------------------------------------------------
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      long_press_q <= bpc_pkg::LONG_RESET;
      hold_press_q <= bpc_pkg::HOLD_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        bpc_pkg::REG_LONG_PRESS: long_press_q <= cfg_data_i;
        bpc_pkg::REG_HOLD_PRESS: hold_press_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Handshake: take a new beat whenever the output register is empty or is
  // being drained in this same cycle.
  // ---------------------------------------------------------------------------
  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  // ---------------------------------------------------------------------------
  // Button lanes, one per button, all updating on the same beat.
  // ---------------------------------------------------------------------------
  for (genvar b = 0; b < bpc_pkg::OUT_BUTTONS; b++) begin : g_btn
    if (b < LANES) begin : g_lane
      bpc_pkg::lane_ctrl_t ctrl;
      assign ctrl.accept = accept;
      assign ctrl.rise   = rising_mask_i[b];
      assign ctrl.fall   = falling_mask_i[b];

      bpc_button_lane u_lane (
        .clk_i           (clk_i),
        .rst_ni          (rst_ni),
        .ctrl_i          (ctrl),
        .now_ms_i        (now_ms_i),
        .long_press_ms_i (long_press_q),
        .hold_press_ms_i (hold_press_q),
        .press_class_o   (lane_class[b])
      );
    end else begin : g_none
      // no button here: report none forever
      assign lane_class[b] = bpc_pkg::CLASS_NONE;
    end
  end

  // ---------------------------------------------------------------------------
  // Knob scaling, one scaler per knob.
  // ---------------------------------------------------------------------------
  assign knob_raw[0] = knob_raw_0_i;
  assign knob_raw[1] = knob_raw_1_i;
  assign knob_raw[2] = knob_raw_2_i;
  assign knob_raw[3] = knob_raw_3_i;

  // ---------------------------------------------------------------------------
  // Merge: gather lane classes and scaled knobs into the output register.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      for (int b = 0; b < bpc_pkg::OUT_BUTTONS; b++) begin
        class_q[b] <= lane_class[b];
      end
      for (int k = 0; k < bpc_pkg::KNOB_COUNT; k++) begin
        knob_q[k] <= bpc_pkg::knob_scale(knob_raw[k]);
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign press_class_0_o = class_q[0];
  assign press_class_1_o = class_q[1];
  assign press_class_2_o = class_q[2];
  assign press_class_3_o = class_q[3];
  assign knob_scaled_0_o = knob_q[0];
  assign knob_scaled_1_o = knob_q[1];
  assign knob_scaled_2_o = knob_q[2];
  assign knob_scaled_3_o = knob_q[3];

`ifndef SYNTHESIS
  // every accepted beat shows up as a result on the next cycle
  a_accept_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> out_valid_o)
    else $error("accepted beat did not produce a result");

  // a full output register that is not drained must block the input side
  a_full_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |-> in_stall_o)
    else $error("input accepted while result is stalled");

  // ports without a button behind them report none
  a_unused_button_none: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (BUTTON_COUNT > 1 || press_class_1_o == bpc_pkg::CLASS_NONE) &&
                    (BUTTON_COUNT > 2 || press_class_2_o == bpc_pkg::CLASS_NONE) &&
                    (BUTTON_COUNT > 3 || press_class_3_o == bpc_pkg::CLASS_NONE))
    else $error("class reported for a missing button");
`endif

endmodule

>>> test/tb_button_press_classifier.sv
// Self-checking testbench for the button press classifier: directed table, then random beats.
`timescale 1ns / 1ps
module tb_button_press_classifier;

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned DRAIN_CYCLES = 6;
  localparam int unsigned HOLD_OFF_LEN = 80;

  // Register indexes past the two thresholds; the block must ignore writes to them.
  localparam logic [bpc_pkg::CFG_INDEX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [bpc_pkg::CFG_INDEX_W-1:0] REG_SPARE_B = 2'd3;

  // One result beat: press classes and scaled knobs, index 3 down to 0.
  typedef struct packed {
    logic [bpc_pkg::OUT_BUTTONS-1:0][1:0]                cls;
    logic [bpc_pkg::KNOB_COUNT-1:0][bpc_pkg::SCALED_W-1:0] knob;
  } result_t;

  // One input beat; typed rows also carry the result read off by hand.
  typedef struct packed {
    logic [bpc_pkg::MASK_W-1:0]                        rise;
    logic [bpc_pkg::MASK_W-1:0]                        fall;
    logic [bpc_pkg::STAMP_W-1:0]                       now;
    logic [bpc_pkg::KNOB_COUNT-1:0][bpc_pkg::RAW_W-1:0] knob;
    logic                                              typed;
    result_t                                           want;
  } stim_row_t;

  localparam logic [bpc_pkg::OUT_BUTTONS-1:0][1:0] ALL_NONE  = {4{bpc_pkg::CLASS_NONE}};
  localparam logic [bpc_pkg::OUT_BUTTONS-1:0][1:0] ALL_SHORT = {4{bpc_pkg::CLASS_SHORT}};

  // Directed walk at reset thresholds (long 500 ms, hold 1000 ms).
  // Class vectors list button 3 first, button 0 last.
  localparam int unsigned DIRECTED_ROWS = 19;
  localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
    // quiet update straight after reset, knobs at zero
    '{4'h0, 4'h0, 32'd0, {4{10'd0}}, 1'b1, '{ALL_NONE, {4{16'd0}}}},
    // press all four, knobs at full scale
    '{4'hF, 4'h0, 32'd100, {4{10'd1023}}, 1'b1, '{ALL_NONE, {4{16'd65535}}}},
    // release button 0 after 250 ms: short
    '{4'h0, 4'h1, 32'd350, {4{10'd1}}, 1'b1,
      '{{bpc_pkg::CLASS_NONE, bpc_pkg::CLASS_NONE, bpc_pkg::CLASS_NONE,
         bpc_pkg::CLASS_SHORT}, {4{16'd64}}}},
    // release button 1 after exactly the long threshold: long
    '{4'h0, 4'h2, 32'd600, {4{10'd341}}, 1'b1,
      '{{bpc_pkg::CLASS_NONE, bpc_pkg::CLASS_NONE, bpc_pkg::CLASS_LONG,
         bpc_pkg::CLASS_NONE}, {4{16'd21845}}}},
    // held exactly the hold threshold: not yet hold
    '{4'h0, 4'h0, 32'd1100, {4{10'd682}}, 1'b1, '{ALL_NONE, {4{16'd43690}}}},
    // one past the hold threshold
    '{4'h0, 4'h0, 32'd1101, {4{10'd0}}, 1'b1,
      '{{bpc_pkg::CLASS_HOLD, bpc_pkg::CLASS_HOLD, bpc_pkg::CLASS_NONE,
         bpc_pkg::CLASS_NONE}, {4{16'd0}}}},
    // release after hold reports none
    '{4'h0, 4'h4, 32'd1200, {4{10'd1023}}, 1'b1,
      '{{bpc_pkg::CLASS_HOLD, bpc_pkg::CLASS_NONE, bpc_pkg::CLASS_NONE,
         bpc_pkg::CLASS_NONE}, {4{16'd65535}}}},
    '{4'h0, 4'h8, 32'd1300, {4{10'd0}}, 1'b1, '{ALL_NONE, {4{16'd0}}}},
    // release with no press pending: stays parked
    '{4'h0, 4'h1, 32'd2000, {4{10'd0}}, 1'b1, '{ALL_NONE, {4{16'd0}}}},
    // later press pairs with it; the duration wraps and reads long
    '{4'h1, 4'h0, 32'd2500, {4{10'd0}}, 1'b1,
      '{{bpc_pkg::CLASS_NONE, bpc_pkg::CLASS_NONE, bpc_pkg::CLASS_NONE,
         bpc_pkg::CLASS_LONG}, {4{16'd0}}}},
    // press and release in one update: zero duration
    '{4'hF, 4'hF, 32'd3000, {4{10'd1023}}, 1'b1, '{ALL_SHORT, {4{16'd65535}}}},
    // hold measured across the 2^32 wrap
    '{4'h1, 4'h0, 32'hFFFF_FF00, {4{10'd0}}, 1'b1, '{ALL_NONE, {4{16'd0}}}},
    '{4'h0, 4'h0, 32'h0000_0300, {4{10'd0}}, 1'b1,
      '{{bpc_pkg::CLASS_NONE, bpc_pkg::CLASS_NONE, bpc_pkg::CLASS_NONE,
         bpc_pkg::CLASS_HOLD}, {4{16'd0}}}},
    '{4'h0, 4'h1, 32'h0000_0310, {4{10'd0}}, 1'b1, '{ALL_NONE, {4{16'd0}}}},
    // short press across the wrap
    '{4'h2, 4'h0, 32'hFFFF_FFFF, {4{10'd0}}, 1'b1, '{ALL_NONE, {4{16'd0}}}},
    '{4'h0, 4'h2, 32'h0000_00F0, {4{10'd0}}, 1'b1,
      '{{bpc_pkg::CLASS_NONE, bpc_pkg::CLASS_NONE, bpc_pkg::CLASS_SHORT,
         bpc_pkg::CLASS_NONE}, {4{16'd0}}}},
    // mixed rows, left to the predictor
    '{4'h5, 4'h0, 32'h0000_1234, {10'd3, 10'd1000, 10'd37, 10'd512}, 1'b0, '0},
    '{4'h0, 4'h5, 32'h0000_1427, {10'd1022, 10'd513, 10'd800, 10'd200}, 1'b0, '0},
    '{4'hA, 4'hA, 32'h8000_0000, {10'd511, 10'd2, 10'd999, 10'd64}, 1'b0, '0}
  };

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                            cfg_valid_i = 1'b0;
  logic                            cfg_ready_o;
  logic [bpc_pkg::CFG_INDEX_W-1:0] cfg_index_i = '0;
  logic [bpc_pkg::THRESH_W-1:0]    cfg_data_i = '0;

  logic                        in_valid_i = 1'b0;
  logic                        in_stall_o;
  logic [bpc_pkg::MASK_W-1:0]  rising_mask_i = '0;
  logic [bpc_pkg::MASK_W-1:0]  falling_mask_i = '0;
  logic [bpc_pkg::STAMP_W-1:0] now_ms_i = '0;
  logic [bpc_pkg::RAW_W-1:0]   knob_raw_0_i = '0;
  logic [bpc_pkg::RAW_W-1:0]   knob_raw_1_i = '0;
  logic [bpc_pkg::RAW_W-1:0]   knob_raw_2_i = '0;
  logic [bpc_pkg::RAW_W-1:0]   knob_raw_3_i = '0;

  logic                         out_valid_o;
  logic                         out_stall_i = 1'b1;
  logic [1:0]                   press_class_0_o;
  logic [1:0]                   press_class_1_o;
  logic [1:0]                   press_class_2_o;
  logic [1:0]                   press_class_3_o;
  logic [bpc_pkg::SCALED_W-1:0] knob_scaled_0_o;
  logic [bpc_pkg::SCALED_W-1:0] knob_scaled_1_o;
  logic [bpc_pkg::SCALED_W-1:0] knob_scaled_2_o;
  logic [bpc_pkg::SCALED_W-1:0] knob_scaled_3_o;

  // Predictor copy of the block's thresholds and per-button timing state.
  logic [bpc_pkg::THRESH_W-1:0] long_ms = bpc_pkg::LONG_RESET;
  logic [bpc_pkg::THRESH_W-1:0] hold_ms = bpc_pkg::HOLD_RESET;
  logic [bpc_pkg::STAMP_W-1:0]  press_at     [bpc_pkg::OUT_BUTTONS] = '{default: '0};
  logic [bpc_pkg::STAMP_W-1:0]  release_at   [bpc_pkg::OUT_BUTTONS] = '{default: '0};
  bit                           press_seen   [bpc_pkg::OUT_BUTTONS] = '{default: 1'b0};
  bit                           release_seen [bpc_pkg::OUT_BUTTONS] = '{default: 1'b0};
  bpc_pkg::press_class_e        last_cls     [bpc_pkg::OUT_BUTTONS] =
    '{default: bpc_pkg::CLASS_NONE};

  // Classes and knob values still owed by the block, oldest first.
  result_t pending_results [$];

  // Random generator view of the buttons: a running clock and which buttons are down.
  logic [bpc_pkg::STAMP_W-1:0] now_track = '0;
  bit                          held_down [bpc_pkg::OUT_BUTTONS] = '{default: 1'b0};

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned hold_off_left = 0;
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;

  button_press_classifier u_top (.*);

  always #4 clk_i = ~clk_i;

  // Advance the predictor by one accepted beat and return the result it owes.
  function automatic result_t predict_beat(input stim_row_t row);
    result_t                     r;
    bpc_pkg::press_class_e       cls;
    logic [bpc_pkg::STAMP_W-1:0] span;
    int unsigned                 scaled;
    int                          b;
    for (b = 0; b < bpc_pkg::OUT_BUTTONS; b++) begin
      if (row.rise[b]) begin
        press_at[b]   = row.now;
        press_seen[b] = 1'b1;
      end
      if (row.fall[b]) begin
        release_at[b]   = row.now;
        release_seen[b] = 1'b1;
      end
      if (press_seen[b] && release_seen[b]) begin
        // A pair closes; a press that already reported hold stays silent.
        span = release_at[b] - press_at[b];
        if (last_cls[b] == bpc_pkg::CLASS_HOLD) begin
          cls = bpc_pkg::CLASS_NONE;
        end else if (span < {16'd0, long_ms}) begin
          cls = bpc_pkg::CLASS_SHORT;
        end else begin
          cls = bpc_pkg::CLASS_LONG;
        end
        press_seen[b]   = 1'b0;
        release_seen[b] = 1'b0;
      end else begin
        span = row.now - press_at[b];
        if (press_seen[b] && span > {16'd0, hold_ms}) begin
          cls = bpc_pkg::CLASS_HOLD;
        end else begin
          cls = bpc_pkg::CLASS_NONE;
        end
      end
      last_cls[b] = cls;
      r.cls[b]    = cls;
    end
    for (b = 0; b < bpc_pkg::KNOB_COUNT; b++) begin
      scaled    = row.knob[b] * 32'd65535 / 32'd1023;
      r.knob[b] = scaled[bpc_pkg::SCALED_W-1:0];
    end
    return r;
  endfunction

  // Build one random beat: mostly well-formed press/release traffic, some noise.
  function automatic stim_row_t random_beat();
    stim_row_t   row;
    int unsigned span;
    int unsigned pick;
    int          b;
    row  = '0;
    span = ((long_ms > hold_ms) ? long_ms : hold_ms) / 2 + 50;
    pick = $urandom_range(99);
    // Step time mostly around the thresholds, now and then jump anywhere.
    if (pick < 70) begin
      now_track = now_track + $urandom_range(span);
    end else if (pick < 92) begin
      now_track = now_track + $urandom_range(3 * span);
    end else begin
      now_track = $urandom;
    end
    row.now = now_track;
    if ($urandom_range(99) < 80) begin
      for (b = 0; b < bpc_pkg::OUT_BUTTONS; b++) begin
        if ($urandom_range(99) < 3) begin
          row.rise[b]  = 1'b1;
          row.fall[b]  = 1'b1;
          held_down[b] = 1'b0;
        end else if ($urandom_range(99) < 30) begin
          row.rise[b]  = !held_down[b];
          row.fall[b]  = held_down[b];
          held_down[b] = !held_down[b];
        end
      end
    end else begin
      row.rise = 4'($urandom_range(15));
      row.fall = 4'($urandom_range(15));
    end
    for (b = 0; b < bpc_pkg::KNOB_COUNT; b++) begin
      pick = $urandom_range(19);
      if (pick == 0) begin
        row.knob[b] = '0;
      end else if (pick == 1) begin
        row.knob[b] = '1;
      end else begin
        row.knob[b] = 10'($urandom_range(1023));
      end
    end
    return row;
  endfunction

  // Offer one beat after a random gap; hold it until the block takes it.
  task automatic send_beat(input stim_row_t row);
    result_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i     <= 1'b1;
    rising_mask_i  <= row.rise;
    falling_mask_i <= row.fall;
    now_ms_i       <= row.now;
    knob_raw_0_i   <= row.knob[0];
    knob_raw_1_i   <= row.knob[1];
    knob_raw_2_i   <= row.knob[2];
    knob_raw_3_i   <= row.knob[3];
    @(posedge clk_i);
    while (in_stall_o) begin
      @(posedge clk_i);
    end
    // Always run the predictor so its state tracks the block; typed rows win.
    predicted = predict_beat(row);
    pending_results.push_back(row.typed ? row.want : predicted);
  endtask

  // Write one register; the predictor follows at the handshake edge.
  task automatic write_reg(input logic [bpc_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [bpc_pkg::THRESH_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) begin
      @(posedge clk_i);
    end
    unique case (idx)
      bpc_pkg::REG_LONG_PRESS: long_ms = data;
      bpc_pkg::REG_HOLD_PRESS: hold_ms = data;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Drop valid, wait for every owed result, then let the pipeline run idle to drain.
  task automatic settle_idle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Reprogram both thresholds (and poke the spare indexes), then run random beats.
  // A long receiver hold-off starts at beat stall_at, if it is in range.
  task automatic run_random(input logic [bpc_pkg::THRESH_W-1:0] long_v,
                            input logic [bpc_pkg::THRESH_W-1:0] hold_v,
                            input int count, input int stall_at);
    int i;
    settle_idle();
    write_reg(bpc_pkg::REG_LONG_PRESS, long_v);
    write_reg(bpc_pkg::REG_HOLD_PRESS, hold_v);
    write_reg(REG_SPARE_A, 16'($urandom));
    write_reg(REG_SPARE_B, 16'($urandom));
    for (i = 0; i < count; i++) begin
      if (i == stall_at) begin
        hold_off_left = HOLD_OFF_LEN;
      end
      send_beat(random_beat());
    end
  endtask

  // Receiver: random stalls at the current rate, or a counted hold-off when asked.
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_off_left > 0) begin
        out_stall_i   <= 1'b1;
        hold_off_left = hold_off_left - 1;
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // Compare each accepted result beat with the oldest owed result.
  always @(posedge clk_i) begin : check_results
    result_t want;
    result_t got;
    int      b;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.cls  = {press_class_3_o, press_class_2_o, press_class_1_o, press_class_0_o};
      got.knob = {knob_scaled_3_o, knob_scaled_2_o, knob_scaled_1_o, knob_scaled_0_o};
      if (pending_results.size() == 0) begin
        $error("result beat with no outstanding input beat");
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        for (b = 0; b < bpc_pkg::OUT_BUTTONS; b++) begin
          if (got.cls[b] !== want.cls[b]) begin
            $error("press_class_%0d: expected %0d, actual %0d", b, want.cls[b], got.cls[b]);
            mismatches++;
          end
        end
        for (b = 0; b < bpc_pkg::KNOB_COUNT; b++) begin
          if (got.knob[b] !== want.knob[b]) begin
            $error("knob_scaled_%0d: expected %0d, actual %0d", b, want.knob[b], got.knob[b]);
            mismatches++;
          end
        end
      end
    end
  end

  // Watchdog: stop a hung run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    int i;
    // Hold reset, then release it away from the rising edge.
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed table at reset thresholds; sender lightly idle, receiver heavily.
    send_idle_pct = 16;
    recv_idle_pct = 63;
    for (i = 0; i < DIRECTED_ROWS; i++) begin
      send_beat(DIRECTED[i]);
    end
    now_track = DIRECTED[DIRECTED_ROWS-1].now;

    // Ordinary thresholds, with one long receiver hold-off to back the block up.
    run_random(16'd200, 16'd700, 470, 120);

    // Zero thresholds: no release reads short, and a press held past its own stamp is hold.
    send_idle_pct = 63;
    recv_idle_pct = 16;
    run_random(16'd0, 16'd0, 470, -1);

    // Full-scale thresholds, then random ones, with both sides streaming.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(16'hFFFF, 16'hFFFF, 230, -1);
    run_random(16'($urandom), 16'($urandom), 230, -1);

    settle_idle();
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
